// File: src/go_back_n_sender_assert.svh
// Assertion macros for the go-back-n sender.
`ifndef GO_BACK_N_SENDER_ASSERT_SVH
`define GO_BACK_N_SENDER_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define GBN_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: src/gbn_pkg.sv
// Types, constants and codes shared by the go-back-n sender modules.
`default_nettype none

package gbn_pkg;

	localparam int SEQ_BITS     = 4;
	localparam int SEQ_SPACE    = 1 << SEQ_BITS;
	localparam int PAYLOAD_BITS = 32;
	localparam int WINDOW       = 8;
	localparam int MAX_RESULTS  = 10;
	localparam int WIN_A        = (WINDOW > SEQ_SPACE - 1) ? SEQ_SPACE - 1 : WINDOW;
	localparam int WIN_B        = (WIN_A > MAX_RESULTS - 2) ? MAX_RESULTS - 2 : WIN_A;
	localparam int EFF_WINDOW   = (WIN_B < 1) ? 1 : WIN_B;
	localparam int CNT_BITS     = $clog2(EFF_WINDOW + 1);
	localparam int TIMER_BITS   = 16;
	localparam int ADDR_BITS    = 3;
	localparam int DATA_BITS    = 32;

	localparam logic [SEQ_BITS-1:0]   WIN_LIM       = SEQ_BITS'(EFF_WINDOW);
	localparam logic [TIMER_BITS-1:0] TIMEOUT_RESET = TIMER_BITS'(1000);
	localparam logic [0:0]            REG_TIMEOUT   = 1'b0;

	typedef enum logic [1:0] {
		KIND_SEND    = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_TIMEOUT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ACT_TRANSMIT    = 3'd0,
		ACT_TIMER_STOP  = 3'd1,
		ACT_TIMER_START = 3'd2,
		ACT_REFUSED     = 3'd3,
		ACT_IGNORED     = 3'd4,
		ACT_NOTHING     = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SINGLE,
		CS_STOP,
		CS_START,
		CS_TX_RD,
		CS_TX_EMIT
	} ctl_state_t;

	typedef enum logic [1:0] {
		RES_SINGLE,
		RES_STOP,
		RES_START,
		RES_TX
	} res_sel_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [SEQ_BITS-1:0]     ack_number;
		logic                    ack_intact;
		logic [SEQ_BITS-1:0]     timer_tag;
	} in_item_t;

	typedef struct packed {
		logic [2:0]              action;
		logic [SEQ_BITS-1:0]     packet_seq;
		logic [PAYLOAD_BITS-1:0] packet_payload;
		logic [SEQ_BITS-1:0]     timer_id;
		logic [TIMER_BITS-1:0]   timer_length;
		logic                    window_full;
		logic                    last;
	} out_item_t;

	typedef struct packed {
		logic     accept;
		logic     emit;
		res_sel_t sel;
		logic     rd_en;
	} dp_cmd_t;

	typedef struct packed {
		ctl_state_t first_step;
		logic       has_start;
		logic       tx_zero;
		logic       tx_last;
		logic       out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: src/gbn_cfg.sv
// APB-style configuration register block holding the timer duration.
`default_nettype none

module gbn_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [gbn_pkg::ADDR_BITS-1:0]    paddr,
	input  wire logic [gbn_pkg::DATA_BITS-1:0]    pwdata,
	output logic      [gbn_pkg::DATA_BITS-1:0]    prdata,
	output logic                                  pready,
	output logic      [gbn_pkg::TIMER_BITS-1:0]   timeout_ticks
);

	logic [gbn_pkg::TIMER_BITS-1:0] timeout_q;
	logic                           hit;

	assign hit    = (paddr[gbn_pkg::ADDR_BITS-1:2] == gbn_pkg::REG_TIMEOUT);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= gbn_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && hit) begin
			timeout_q <= pwdata[gbn_pkg::TIMER_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = gbn_pkg::DATA_BITS'(timeout_q);
		end
	end

	assign timeout_ticks = timeout_q;

endmodule

`default_nettype wire

// File: src/gbn_ctrl.sv
// Controller state machine sequencing the results of one item.
`default_nettype none

module gbn_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire gbn_pkg::dp_stat_t stat,
	output gbn_pkg::dp_cmd_t       cmd
);

	gbn_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbn_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.emit   = 1'b0;
		cmd.sel    = gbn_pkg::RES_SINGLE;
		cmd.rd_en  = 1'b0;
		case (state_q)
			gbn_pkg::CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = stat.first_step;
				end
			end
			gbn_pkg::CS_SINGLE: begin
				cmd.sel = gbn_pkg::RES_SINGLE;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = gbn_pkg::CS_IDLE;
				end
			end
			gbn_pkg::CS_STOP: begin
				cmd.sel = gbn_pkg::RES_STOP;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.has_start) begin
						state_d = gbn_pkg::CS_START;
					end else if (stat.tx_zero) begin
						state_d = gbn_pkg::CS_IDLE;
					end else begin
						state_d = gbn_pkg::CS_TX_RD;
					end
				end
			end
			gbn_pkg::CS_START: begin
				cmd.sel = gbn_pkg::RES_START;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.tx_zero ? gbn_pkg::CS_IDLE : gbn_pkg::CS_TX_RD;
				end
			end
			gbn_pkg::CS_TX_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = gbn_pkg::CS_TX_EMIT;
			end
			gbn_pkg::CS_TX_EMIT: begin
				cmd.sel = gbn_pkg::RES_TX;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.tx_last ? gbn_pkg::CS_IDLE : gbn_pkg::CS_TX_RD;
				end
			end
			default: begin
				state_d = gbn_pkg::CS_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/gbn_dp.sv
// Datapath: window pointers, packet buffer, per-item plan and output register.
`default_nettype none

module gbn_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire gbn_pkg::in_item_t              in_data,
	input  wire logic [gbn_pkg::TIMER_BITS-1:0] timeout_ticks,
	input  wire gbn_pkg::dp_cmd_t               cmd,
	output gbn_pkg::dp_stat_t                   stat,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output gbn_pkg::out_item_t                  out_data
);

	localparam int SB = gbn_pkg::SEQ_BITS;
	localparam int CB = gbn_pkg::CNT_BITS;

	logic [SB-1:0]                   base_q, next_q;
	logic [gbn_pkg::PAYLOAD_BITS-1:0] mem_q [gbn_pkg::SEQ_SPACE];
	logic [gbn_pkg::PAYLOAD_BITS-1:0] rd_q;

	// plan of the item in progress
	logic [2:0]    single_q;
	logic [SB-1:0] stop_id_q, start_id_q, tx_seq_q;
	logic          has_start_q, full_q;
	logic [CB-1:0] tx_cnt_q;

	logic [2:0]    p_single;
	logic [SB-1:0] p_stop, p_start, p_seq, base_d, next_d;
	logic          p_has_start, p_full, wr_en;
	logic [CB-1:0] p_cnt;
	gbn_pkg::ctl_state_t p_first;

	logic [SB-1:0] cnt, ack_d, ack_next;
	logic          is_send;

	logic                           out_valid_q;
	gbn_pkg::out_item_t             out_q, res;
	logic [gbn_pkg::TIMER_BITS-1:0] tlen;

	assign cnt      = next_q - base_q;
	assign ack_d    = in_data.ack_number - base_q;
	assign ack_next = in_data.ack_number + SB'(1);
	assign is_send  = (in_data.kind == gbn_pkg::KIND_SEND);

	always_comb begin
		p_single    = gbn_pkg::ACT_NOTHING;
		p_stop      = base_q;
		p_start     = base_q;
		p_has_start = 1'b0;
		p_cnt       = '0;
		p_seq       = base_q;
		p_first     = gbn_pkg::CS_SINGLE;
		p_full      = (cnt >= gbn_pkg::WIN_LIM);
		base_d      = base_q;
		next_d      = next_q;
		wr_en       = 1'b0;
		case (in_data.kind)
			gbn_pkg::KIND_SEND: begin
				if (cnt >= gbn_pkg::WIN_LIM) begin
					p_single = gbn_pkg::ACT_REFUSED;
				end else begin
					wr_en       = 1'b1;
					next_d      = next_q + SB'(1);
					p_has_start = (cnt == '0);
					p_cnt       = CB'(1);
					p_seq       = next_q;
					p_first     = (cnt == '0) ? gbn_pkg::CS_START : gbn_pkg::CS_TX_EMIT;
					p_full      = ((cnt + SB'(1)) >= gbn_pkg::WIN_LIM);
				end
			end
			gbn_pkg::KIND_ACK: begin
				if (!in_data.ack_intact || ack_d >= cnt) begin
					p_single = gbn_pkg::ACT_IGNORED;
				end else begin
					base_d      = ack_next;
					p_stop      = base_q;
					p_start     = ack_next;
					p_has_start = (ack_next != next_q);
					p_first     = gbn_pkg::CS_STOP;
					p_full      = ((next_q - ack_next) >= gbn_pkg::WIN_LIM);
				end
			end
			gbn_pkg::KIND_TIMEOUT: begin
				if (cnt != '0) begin
					p_stop      = in_data.timer_tag;
					p_start     = in_data.timer_tag;
					p_has_start = 1'b1;
					p_cnt       = CB'(cnt);
					p_seq       = base_q;
					p_first     = gbn_pkg::CS_STOP;
				end
			end
			default: begin
				p_single = gbn_pkg::ACT_NOTHING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_q      <= '0;
			has_start_q <= 1'b0;
			tx_cnt_q    <= '0;
		end else if (cmd.accept) begin
			base_q      <= base_d;
			next_q      <= next_d;
			has_start_q <= p_has_start;
			tx_cnt_q    <= p_cnt;
		end else if (cmd.emit && cmd.sel == gbn_pkg::RES_TX) begin
			tx_cnt_q <= tx_cnt_q - CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			single_q   <= p_single;
			stop_id_q  <= p_stop;
			start_id_q <= p_start;
			tx_seq_q   <= p_seq;
			full_q     <= p_full;
		end else if (cmd.emit && cmd.sel == gbn_pkg::RES_TX) begin
			tx_seq_q <= tx_seq_q + SB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en) begin
			mem_q[next_q] <= in_data.payload;
		end
	end

	// the send path loads the read register directly, bypassing the buffer
	always_ff @(posedge clk) begin
		if (cmd.accept && is_send) begin
			rd_q <= in_data.payload;
		end else if (cmd.rd_en) begin
			rd_q <= mem_q[tx_seq_q];
		end
	end

	assign tlen = (timeout_ticks == '0) ? gbn_pkg::TIMER_BITS'(1) : timeout_ticks;

	always_comb begin
		res             = '0;
		res.window_full = full_q;
		case (cmd.sel)
			gbn_pkg::RES_SINGLE: begin
				res.action = single_q;
				res.last   = 1'b1;
			end
			gbn_pkg::RES_STOP: begin
				res.action   = gbn_pkg::ACT_TIMER_STOP;
				res.timer_id = stop_id_q;
				res.last     = !has_start_q && (tx_cnt_q == '0);
			end
			gbn_pkg::RES_START: begin
				res.action       = gbn_pkg::ACT_TIMER_START;
				res.timer_id     = start_id_q;
				res.timer_length = tlen;
				res.last         = (tx_cnt_q == '0);
			end
			gbn_pkg::RES_TX: begin
				res.action         = gbn_pkg::ACT_TRANSMIT;
				res.packet_seq     = tx_seq_q;
				res.packet_payload = rd_q;
				res.last           = (tx_cnt_q == CB'(1));
			end
			default: begin
				res.action = gbn_pkg::ACT_NOTHING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.first_step = p_first;
	assign stat.has_start  = has_start_q;
	assign stat.tx_zero    = (tx_cnt_q == '0);
	assign stat.tx_last    = (tx_cnt_q == CB'(1));
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// File: src/go_back_n_sender.sv
// Go-back-n sender top level: config registers, controller and datapath.
// The first result is registered after an accept, once the output register is free.
// New items are taken only in idle, after the last result of the previous one;
// a send that starts the timer emits the start, then reads and transmits its packet;
// a timeout emits a stop and a start, then a buffer read and a transmit per packet.
// Reset: arst_n clears the window pointers and controller and sets the timer to 1000.
`default_nettype none
`include "go_back_n_sender_assert.svh"

module go_back_n_sender (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire gbn_pkg::in_item_t                in_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output gbn_pkg::out_item_t                    out_data,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [gbn_pkg::ADDR_BITS-1:0]    paddr,
	input  wire logic [gbn_pkg::DATA_BITS-1:0]    pwdata,
	output logic      [gbn_pkg::DATA_BITS-1:0]    prdata,
	output logic                                  pready
);

	logic [gbn_pkg::TIMER_BITS-1:0] timeout_ticks;
	gbn_pkg::dp_cmd_t               cmd;
	gbn_pkg::dp_stat_t              stat;

	gbn_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_ticks (timeout_ticks)
	);

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gbn_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_data       (in_data),
		.timeout_ticks (timeout_ticks),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

	`GBN_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`GBN_ASSERT_NEXT(a_emit_loads_out, cmd.emit, out_valid, "emitted result not presented")
	`GBN_ASSERT_SAME(a_read_while_busy, cmd.rd_en, !in_ready && !cmd.emit, "buffer read when idle")

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the go-back-n sender: event stream, window tracking, APB setup.
module tb;
	import gbn_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 70;

	// Tracks the send window and holds the actions still due from the block.
	class sender_tracker;
		logic [SEQ_BITS-1:0]     base;
		logic [SEQ_BITS-1:0]     next_seq;
		logic [PAYLOAD_BITS-1:0] sent [SEQ_SPACE];
		logic [TIMER_BITS-1:0]   ticks;
		out_item_t               due_actions [$];
		out_item_t               batch [$];
		int                      mismatches;

		function new();
			base = '0;
			next_seq = '0;
			ticks = TIMEOUT_RESET;
			mismatches = 0;
		endfunction

		function int unsigned in_flight();
			logic [SEQ_BITS-1:0] d;
			d = next_seq - base;
			return 32'(d);
		endfunction

		function logic [TIMER_BITS-1:0] timer_len();
			return (ticks == '0) ? TIMER_BITS'(1) : ticks;
		endfunction

		function void add(action_t act, logic [SEQ_BITS-1:0] seq,
				logic [PAYLOAD_BITS-1:0] pay, logic [SEQ_BITS-1:0] id,
				logic [TIMER_BITS-1:0] len);
			out_item_t r;
			r = '0;
			r.action = act;
			r.packet_seq = seq;
			r.packet_payload = pay;
			r.timer_id = id;
			r.timer_length = len;
			batch.push_back(r);
		endfunction

		// Called on each input transfer: updates the window, queues the actions due.
		function void take_event(in_item_t ev);
			logic [SEQ_BITS-1:0] ack_offset;
			logic [SEQ_BITS-1:0] old_base;
			logic [SEQ_BITS-1:0] s;
			int unsigned         cnt;
			logic                full;
			cnt = in_flight();
			batch.delete();
			case (ev.kind)
			KIND_SEND: begin
				if (cnt >= EFF_WINDOW) begin
					add(ACT_REFUSED, '0, '0, '0, '0);
				end else begin
					sent[next_seq] = ev.payload;
					if (cnt == 0)
						add(ACT_TIMER_START, '0, '0, base, timer_len());
					add(ACT_TRANSMIT, next_seq, ev.payload, '0, '0);
					next_seq = next_seq + 1'b1;
				end
			end
			KIND_ACK: begin
				ack_offset = ev.ack_number - base;
				if (!ev.ack_intact || ack_offset >= cnt) begin
					add(ACT_IGNORED, '0, '0, '0, '0);
				end else begin
					old_base = base;
					base = ev.ack_number + 1'b1;
					add(ACT_TIMER_STOP, '0, '0, old_base, '0);
					if (base != next_seq)
						add(ACT_TIMER_START, '0, '0, base, timer_len());
				end
			end
			KIND_TIMEOUT: begin
				if (cnt == 0) begin
					add(ACT_NOTHING, '0, '0, '0, '0);
				end else begin
					add(ACT_TIMER_STOP, '0, '0, ev.timer_tag, '0);
					add(ACT_TIMER_START, '0, '0, ev.timer_tag, timer_len());
					for (int unsigned i = 0; i < cnt; i++) begin
						s = base + SEQ_BITS'(i);
						add(ACT_TRANSMIT, s, sent[s], '0, '0);
					end
				end
			end
			default: begin
				add(ACT_NOTHING, '0, '0, '0, '0);
			end
			endcase
			full = (in_flight() >= EFF_WINDOW);
			foreach (batch[i]) begin
				batch[i].window_full = full;
				batch[i].last = (i == batch.size() - 1);
				due_actions.push_back(batch[i]);
			end
		endfunction

		function void check_field(string name, logic [PAYLOAD_BITS-1:0] want,
				logic [PAYLOAD_BITS-1:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		// Called on each output transfer.
		function void check_action(out_item_t got);
			out_item_t want;
			if (due_actions.size() == 0) begin
				$display("%0t: action expected none, got %0h", $time, got);
				mismatches++;
				return;
			end
			want = due_actions.pop_front();
			check_field("action", want.action, got.action);
			check_field("packet_seq", want.packet_seq, got.packet_seq);
			check_field("packet_payload", want.packet_payload, got.packet_payload);
			check_field("timer_id", want.timer_id, got.timer_id);
			check_field("timer_length", want.timer_length, got.timer_length);
			check_field("window_full", want.window_full, got.window_full);
			check_field("last", want.last, got.last);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	sender_tracker tracker;
	bit            no_gaps;
	bit            hold_long;
	int            idle_cycles;

	go_back_n_sender dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic offer(in_item_t ev);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ev;
		do @(posedge clk); while (!in_ready);
		tracker.take_event(ev);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.due_actions.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(logic [TIMER_BITS-1:0] ticks);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'(4 * REG_TIMEOUT);
		pwdata <= {16'($urandom), ticks};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.ticks = ticks;
	endtask

	function automatic in_item_t make_event(logic [1:0] kind, logic [PAYLOAD_BITS-1:0] pay,
			logic [SEQ_BITS-1:0] ackn, logic intact, logic [SEQ_BITS-1:0] tag);
		in_item_t ev;
		ev.kind = kind;
		ev.payload = pay;
		ev.ack_number = ackn;
		ev.ack_intact = intact;
		ev.timer_tag = tag;
		return ev;
	endfunction

	// Mostly well-formed traffic: acks usually land inside the in-flight range.
	function automatic in_item_t pick_event();
		in_item_t    ev;
		int unsigned cnt;
		int unsigned roll;
		ev = make_event(KIND_SEND, $urandom, SEQ_BITS'($urandom_range(0, 15)),
			1'($urandom_range(0, 1)), SEQ_BITS'($urandom_range(0, 15)));
		cnt = tracker.in_flight();
		roll = $urandom_range(0, 99);
		if (roll < 48) begin
			ev.kind = KIND_SEND;
		end else if (roll < 80) begin
			ev.kind = KIND_ACK;
			if (cnt > 0 && $urandom_range(0, 9) < 8) begin
				ev.ack_number = tracker.base + SEQ_BITS'($urandom_range(0, cnt - 1));
				ev.ack_intact = 1'b1;
			end
		end else if (roll < 95) begin
			ev.kind = KIND_TIMEOUT;
		end else begin
			ev.kind = KIND_UNUSED;
		end
		return ev;
	endfunction

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_long) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_long = 1'b0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 4);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			tracker.check_action(out_data);
		end
	end

	initial begin
		logic [TIMER_BITS-1:0] settings [PHASES];
		tracker = new();
		idle_cycles = 0;
		no_gaps = 1'b0;
		hold_long = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, timer at its reset length
		offer(make_event(KIND_TIMEOUT, $urandom, 4'd0, 1'b1, 4'd15));  // empty window
		offer(make_event(KIND_ACK, '0, 4'd0, 1'b1, 4'd0));              // nothing in flight
		offer(make_event(KIND_UNUSED, '1, 4'd15, 1'b1, 4'd15));
		offer(make_event(KIND_SEND, '0, 4'd15, 1'b0, 4'd0));             // starts timer
		offer(make_event(KIND_SEND, '1, 4'd0, 1'b1, 4'd0));
		offer(make_event(KIND_ACK, $urandom, 4'd0, 1'b0, 4'd0));         // corrupted ack
		offer(make_event(KIND_ACK, $urandom, 4'd15, 1'b1, 4'd0));        // out of range
		offer(make_event(KIND_ACK, $urandom, 4'd0, 1'b1, 4'd0));         // slide and restart
		offer(make_event(KIND_TIMEOUT, $urandom, 4'd0, 1'b0, 4'd15));
		for (int i = 0; i < 7; i++)
			offer(make_event(KIND_SEND, i[0] ? 32'hA5A5_A5A5 : 32'h5A5A_5A5A, 4'd0, 1'b0, 4'd0));
		offer(make_event(KIND_SEND, 32'h1234_5678, 4'd0, 1'b1, 4'd0));   // window full
		offer(make_event(KIND_TIMEOUT, $urandom, 4'd0, 1'b1, 4'd0));     // resend whole window
		offer(make_event(KIND_ACK, $urandom, 4'd8, 1'b1, 4'd15));        // window empties
		offer(make_event(KIND_ACK, $urandom, 4'd8, 1'b1, 4'd15));        // stale
		drain();

		settings[0] = '0;
		settings[1] = '1;
		settings[2] = TIMER_BITS'(1);
		settings[3] = TIMER_BITS'($urandom_range(2, 65534));
		settings[4] = TIMER_BITS'($urandom_range(2, 65534));
		settings[5] = TIMER_BITS'(1000);
		for (int p = 0; p < PHASES; p++) begin
			write_timeout(settings[p]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 20 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				if (p == 3 && k == 10)
					hold_long = 1'b1;
				offer(pick_event());
			end
			drain();
		end
		repeat (8) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.due_actions.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// File: sim.f
+incdir+src
src/gbn_pkg.sv
src/gbn_cfg.sv
src/gbn_ctrl.sv
src/gbn_dp.sv
src/go_back_n_sender.sv
test/tb.sv
